// ----- hw/rtl/md5sh_pkg.sv -----
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types and constants of the MD5 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package md5sh_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  // Controller to datapath
  typedef struct packed {
    logic        buf_wr;     // write the wr_sel-selected word at wr_pos
    logic [3:0]  wr_pos;
    logic [1:0]  wr_sel;     // source of the buffer word
    logic        cnt_add;    // add cnt_inc to the byte count
    logic [2:0]  cnt_inc;
    logic        rnd_init;   // load working regs from chaining value
    logic        rnd_en;     // run one step
    logic [5:0]  rnd_idx;
    logic        cv_fold;    // add working regs into chaining value
    logic        clr;        // return to initial state
  } md5sh_cmd_t;

  localparam logic [1:0] SEL_MSG  = 2'd0;
  localparam logic [1:0] SEL_ZERO = 2'd1;
  localparam logic [1:0] SEL_LLO  = 2'd2;
  localparam logic [1:0] SEL_LHI  = 2'd3;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] md5_s(input logic [1:0] r, input logic [1:0] j);
    logic [4:0] s;
    begin
      case ({r, j})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/md5sh_datapath.sv -----
// ----------------------------------------------------------------------------
// md5sh_datapath
// Block buffer, byte count, chaining value and one MD5 step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module md5sh_datapath
  import md5sh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire md5sh_cmd_t  cmd,
  input  wire logic [31:0] msg_word,
  output logic [31:0]      cv_word [4]
);

  logic [31:0] blk [16];
  logic [63:0] byte_count;
  logic [31:0] cv [4];
  logic [31:0] a, b, c, d;
  logic [31:0] wr_data, f, sum, rot;
  logic [3:0]  g;
  logic [4:0]  s;
  logic [63:0] bit_len;

  assign bit_len = {byte_count[60:0], 3'b000};

  always_comb begin
    case (cmd.wr_sel)
      SEL_MSG:  wr_data = msg_word;
      SEL_ZERO: wr_data = '0;
      SEL_LLO:  wr_data = bit_len[31:0];
      default:  wr_data = bit_len[63:32];
    endcase
  end

  always_comb begin
    case (cmd.rnd_idx[5:4])
      2'd0: begin f = d ^ (b & (c ^ d)); g = cmd.rnd_idx[3:0]; end
      2'd1: begin
        f = c ^ (d & (b ^ c));
        g = 4'(5 * cmd.rnd_idx[3:0] + 1);
      end
      2'd2: begin f = b ^ c ^ d; g = 4'(3 * cmd.rnd_idx[3:0] + 5); end
      default: begin f = c ^ (b | ~d); g = 4'(7 * cmd.rnd_idx[3:0]); end
    endcase
    s   = md5_s(cmd.rnd_idx[5:4], cmd.rnd_idx[1:0]);
    sum = a + f + md5_k(cmd.rnd_idx) + blk[g];
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      blk[cmd.wr_pos] <= wr_data;
    end
    if (cmd.rnd_init) begin
      a <= cv[0]; b <= cv[1]; c <= cv[2]; d <= cv[3];
    end else if (cmd.rnd_en) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      byte_count <= '0;
      cv[0] <= IV_A; cv[1] <= IV_B; cv[2] <= IV_C; cv[3] <= IV_D;
    end else begin
      if (cmd.cnt_add) begin
        byte_count <= byte_count + 64'(cmd.cnt_inc);
      end
      if (cmd.cv_fold) begin
        cv[0] <= cv[0] + a; cv[1] <= cv[1] + b;
        cv[2] <= cv[2] + c; cv[3] <= cv[3] + d;
      end
    end
  end

  assign cv_word = cv;

endmodule
`default_nettype wire

// ----- hw/rtl/md5sh_ctrl.sv -----
// ----------------------------------------------------------------------------
// md5sh_ctrl
// Sequencer: word intake, padding, length, rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module md5sh_ctrl
  import md5sh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_word,
  input  wire logic [2:0]  in_nbytes,
  input  wire logic        in_final,
  output logic             in_stall,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [1:0]       out_idx,
  output md5sh_cmd_t       cmd,
  output logic [31:0]      msg_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ROUND, S_FOLD, S_PAD, S_OUT
  } state_t;

  state_t     state;
  logic [3:0] pos;
  logic [5:0] rnd;
  logic       fin;       // final word taken; padding and digest still to come
  logic       need80;    // 0x80 word still to write (full final word)
  logic       len_done;  // length written; this block is the last

  logic [2:0]  nb;
  logic [31:0] mask, padded;
  logic        take;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign take      = in_valid && (state == S_IDLE);

  always_comb begin
    nb = (in_nbytes > 3'd4) ? 3'd4 : in_nbytes;
    case (nb)
      3'd0: mask = 32'h0;
      3'd1: mask = 32'h000000ff;
      3'd2: mask = 32'h0000ffff;
      3'd3: mask = 32'h00ffffff;
      default: mask = 32'hffffffff;
    endcase
    padded = (in_word & mask) | (PAD_BYTE << {nb[1:0], 3'b000});
    if (!in_final || nb == 3'd4) begin
      msg_word = in_word;
    end else if (state == S_PAD) begin
      msg_word = PAD_BYTE;
    end else begin
      msg_word = padded;
    end
    if (state == S_PAD && need80) begin
      msg_word = PAD_BYTE;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.wr_pos  = pos;
    cmd.rnd_idx = rnd;
    cmd.wr_sel  = SEL_MSG;
    case (state)
      S_IDLE: begin
        cmd.buf_wr  = take;
        cmd.cnt_add = take;
        cmd.cnt_inc = in_final ? nb : 3'd4;
      end
      S_PAD: begin
        cmd.buf_wr = 1'b1;
        if (need80) begin
          cmd.wr_sel = SEL_MSG;
        end else if (!len_done && pos == 4'd14) begin
          cmd.wr_sel = SEL_LLO;
        end else if (len_done && pos == 4'd15) begin
          cmd.wr_sel = SEL_LHI;
        end else begin
          cmd.wr_sel = SEL_ZERO;
        end
      end
      S_INIT:  cmd.rnd_init = 1'b1;
      S_ROUND: cmd.rnd_en = 1'b1;
      S_FOLD:  cmd.cv_fold = 1'b1;
      S_OUT:   cmd.clr = !out_stall && out_idx == 2'd3;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pos <= '0; rnd <= '0; fin <= 1'b0;
      need80 <= 1'b0; len_done <= 1'b0; out_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (take) begin
          pos <= pos + 4'd1;
          if (in_final) begin
            fin      <= 1'b1;
            need80   <= (nb == 3'd4);
            len_done <= 1'b0;
            state    <= (pos == 4'd15) ? S_INIT : S_PAD;
          end else if (pos == 4'd15) begin
            state <= S_INIT;
          end
        end
        S_PAD: begin
          pos    <= pos + 4'd1;
          need80 <= 1'b0;
          // length low word lands in entry 14 only when padding reaches it
          if (!need80 && !len_done && pos == 4'd14) len_done <= 1'b1;
          if (pos == 4'd15) state <= S_INIT;
        end
        S_INIT: begin
          rnd <= '0; state <= S_ROUND;
          // a final block whose pos-15 entry held no length gets another pass
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          if (!fin) state <= S_IDLE;
          else if (len_done) begin state <= S_OUT; out_idx <= '0; end
          else state <= S_PAD;
        end
        S_OUT: if (!out_stall) begin
          out_idx <= out_idx + 2'd1;
          if (out_idx == 2'd3) begin
            state <= S_IDLE; fin <= 1'b0; pos <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/md5_stream_hasher_core.sv -----
// ----------------------------------------------------------------------------
// md5_stream_hasher_core
// MD5 digest over a stream of little-endian 32-bit message words.
// ----------------------------------------------------------------------------
//  channel | direction | payload                               | handshake
//  input   | in        | message_word, valid_bytes, final_word | in_valid/in_stall
//  output  | out       | digest_word, digest_index, digest_last | out_valid/out_stall
//
// Each accepted word is written to the block buffer. The 16th word of a
// block starts the compression: a load step, 64 rounds (one per cycle on a
// single adder chain) and a fold step.
// The final word adds padding writes (one per cycle up to word 15), one or
// two compressions, then four digest beats held while out_stall is high.
// Input is stalled whenever the sequencer is not idle. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_stream_hasher_core
  import md5sh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] message_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        final_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [1:0]       digest_index,
  output logic             digest_last
);

  md5sh_cmd_t  cmd;
  logic [31:0] msg_word;
  logic [31:0] cv_word [4];

  md5sh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_word(message_word), .in_nbytes(valid_bytes),
    .in_final(final_word), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .out_idx(digest_index),
    .cmd(cmd), .msg_word(msg_word)
  );

  md5sh_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .msg_word(msg_word), .cv_word(cv_word)
  );

  // Drive the selected chaining word straight out; it holds during OUT.
  assign digest_word = cv_word[digest_index];
  assign digest_last = (digest_index == 2'd3);

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for md5_stream_hasher_core: drives whole messages of
// little-endian words, predicts the digest of each one and checks every beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] message_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        final_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  digest_index;
  logic        digest_last;

  md5_stream_hasher_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .message_word(message_word), .valid_bytes(valid_bytes), .final_word(final_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .digest_index(digest_index), .digest_last(digest_last)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        fin;
    bit          typed;   // expected digest typed in by hand
    logic [31:0] ta, tb_, tc, td;
  } stim_row_t;

  // Predictor state
  logic [31:0] hash_cv [4];
  logic [31:0] hash_buf [16];
  int unsigned hash_pos;
  logic [63:0] hash_bytes;

  digest_beat_t digest_q [$];
  stim_row_t    stim_q [$];
  stim_row_t    drive_row;   // row currently on the input pins
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;       // no idling on either side
  bit  hold_off = 1'b0;   // long receiver stall

  localparam int WATCHDOG = 4000;

  const logic [31:0] round_k [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  const int unsigned round_s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                      6, 10, 15, 21};

  task automatic hash_restart();
    hash_cv[0] = md5sh_pkg::IV_A; hash_cv[1] = md5sh_pkg::IV_B;
    hash_cv[2] = md5sh_pkg::IV_C; hash_cv[3] = md5sh_pkg::IV_D;
    hash_pos = 0;
    hash_bytes = '0;
  endtask

  task automatic hash_compress();
    logic [31:0] a, b, c, d, f, t, sum;
    int unsigned g, r;
    a = hash_cv[0]; b = hash_cv[1]; c = hash_cv[2]; d = hash_cv[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = d;
      sum = a + f + round_k[i] + hash_buf[g];
      d = c;
      c = b;
      b = b + ((sum << round_s[r * 4 + i % 4]) | (sum >> (32 - round_s[r * 4 + i % 4])));
      a = t;
    end
    hash_cv[0] += a; hash_cv[1] += b; hash_cv[2] += c; hash_cv[3] += d;
  endtask

  task automatic hash_push(input logic [31:0] w);
    hash_buf[hash_pos] = w;
    hash_pos++;
    if (hash_pos == 16) begin
      hash_compress();
      hash_pos = 0;
    end
  endtask

  // Advance the predictor by one accepted beat; queue the digest on a final word.
  task automatic hash_accept(input logic [31:0] w, input logic [2:0] nb_in, input logic fin);
    int unsigned nb;
    logic [63:0] bits;
    if (!fin) begin
      hash_bytes += 4;
      hash_push(w);
    end else begin
      nb = (nb_in > 4) ? 4 : nb_in;   // oversized final count saturates
      hash_bytes += nb;
      if (nb < 4) hash_push((w & ((32'h1 << (8 * nb)) - 1)) | (32'h80 << (8 * nb)));
      else begin
        hash_push(w);
        hash_push(md5sh_pkg::PAD_BYTE);
      end
      if (hash_pos > 14) while (hash_pos != 0) hash_push('0);
      while (hash_pos < 14) hash_push('0);
      bits = hash_bytes << 3;
      hash_push(bits[31:0]);
      hash_push(bits[63:32]);
      for (int k = 0; k < 4; k++) digest_q.push_back('{hash_cv[k], k[1:0], k == 3});
      hash_restart();
    end
  endtask

  function automatic stim_row_t mk(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    stim_row_t s;
    s = '{w, nb, fin, 1'b0, '0, '0, '0, '0};
    return s;
  endfunction

  // Sender: walk the stimulus list; drop valid only on idle cycles.
  initial begin
    stim_row_t cur;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0) begin
      cur = stim_q.pop_front();
      while (!calm && $urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      message_word <= cur.word;
      valid_bytes <= cur.nbytes;
      final_word <= cur.fin;
      drive_row <= cur;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Accept-side monitor, predictor updated on the accepting edge.
  always @(posedge clk) begin
    digest_beat_t e;
    if (!rst && in_valid && !in_stall) begin
      hash_accept(message_word, valid_bytes, final_word);
      if (final_word && drive_row.typed) begin
        // hand-typed digest: check the predictor agrees with the known answer
        if (digest_q.size() < 4 || digest_q[$-3].word != drive_row.ta
            || digest_q[$-2].word != drive_row.tb_
            || digest_q[$-1].word != drive_row.tc || digest_q[$].word != drive_row.td) begin
          $error("known digest: predictor disagrees");
          errors++;
        end
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("digest beat with nothing expected: word %h", digest_word);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.word) begin
          $error("digest_word expected %h actual %h", e.word, digest_word); errors++;
        end
        if (digest_index !== e.index) begin
          $error("digest_index expected %0d actual %0d", e.index, digest_index); errors++;
        end
        if (digest_last !== e.last) begin
          $error("digest_last expected %0d actual %0d", e.last, digest_last); errors++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Receiver: random stall, a long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 23);
  end

  initial begin
    int count;
    repeat (400) @(posedge clk);
    hold_off = 1'b1;
    count = 0;
    while (count < 600) begin
      @(posedge clk);
      count++;
    end
    hold_off = 1'b0;
  end

  // Watchdog on cycles with no beat at all.
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (quiet_cycles >= WATCHDOG) begin
        $display("md5_stream_hasher_core: mismatch");
        $finish;
      end
    end
  end

  // Build the stimulus, then wait for the drain.
  initial begin
    stim_row_t s;
    int n, nwords;
    hash_restart();
    // empty message
    s = mk('0, 3'd0, 1'b1); s.typed = 1'b1;
    s.ta = 32'hd98c1dd4; s.tb_ = 32'h04b2008f; s.tc = 32'h980980e9; s.td = 32'h7e42f8ec;
    stim_q.push_back(s);
    // "abc"
    s = mk(32'h00636261, 3'd3, 1'b1); s.typed = 1'b1;
    s.ta = 32'h98500190; s.tb_ = 32'hb04fd23c; s.tc = 32'h7d3f96d6; s.td = 32'h727fe128;
    stim_q.push_back(s);
    stim_q.push_back(mk(32'hffffffff, 3'd1, 1'b1));
    stim_q.push_back(mk(32'hffffffff, 3'd2, 1'b1));
    stim_q.push_back(mk(32'hffffffff, 3'd4, 1'b1));
    stim_q.push_back(mk(32'hdeadbeef, 3'd7, 1'b1));   // oversized count saturates
    stim_q.push_back(mk(32'h12345678, 3'd5, 1'b1));
    stim_q.push_back(mk(32'hffffffff, 3'd0, 1'b0));   // short non-final counts as four
    stim_q.push_back(mk(32'h00000000, 3'd6, 1'b0));
    stim_q.push_back(mk(32'haaaa5555, 3'd3, 1'b1));
    // 13 words then a full final: length spills into an extra block
    for (int i = 0; i < 13; i++) stim_q.push_back(mk($urandom, 3'd4, 1'b0));
    stim_q.push_back(mk($urandom, 3'd4, 1'b1));
    n = stim_q.size();
    // random messages, mostly short, a few across several blocks
    while (n < 260) begin
      nwords = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(18);
      for (int i = 0; i < nwords; i++)
        stim_q.push_back(mk($urandom, 3'($urandom_range(7)), 1'b0));
      stim_q.push_back(mk($urandom, 3'($urandom_range(7)), 1'b1));
      n += nwords + 1;
    end
    calm = 1'b0;
    fork
      begin
        repeat (1200) @(posedge clk);
        calm = 1'b1;
        repeat (800) @(posedge clk);
        calm = 1'b0;
      end
    join_none
    wait (stim_done);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("md5_stream_hasher_core: match");
    else $display("md5_stream_hasher_core: mismatch");
    $finish;
  end
endmodule
